// ----- sv/f2dt_pkg.sv -----
package f2dt_pkg;

  // Biased exponent limits of the fixed-point split.
  localparam int EXP_BIAS  = 127;
  localparam int FRAC_BITS = 23;
  localparam logic [7:0] BEXP_LARGE = 8'(EXP_BIAS + 31);
  localparam logic [7:0] BEXP_SMALL = 8'(EXP_BIAS - 23);
  localparam logic [7:0] BEXP_INT   = 8'(EXP_BIAS + FRAC_BITS);
  localparam logic [7:0] BEXP_ONE   = 8'(EXP_BIAS);
  localparam logic [7:0] BEXP_HALF  = 8'(EXP_BIAS - 1);

  localparam int TEXT_BUFFER_LEN = 15;
  localparam int MAX_TEXT        = 14;

  // Integer part is below 2^31, so at most ten decimal digits.
  localparam int IPART_W = 31;
  localparam int IDIG_N  = 10;
  localparam int NDIG_W  = $clog2(IDIG_N + 1);
  localparam int IDX_IW  = $clog2(IDIG_N);

  // Reciprocal of ten: q = (x * RECIP10) >> RECIP_SH is exact for x < 2^32.
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;
  localparam int          PROD_W   = IPART_W + 32;
  localparam int          QUOT_W   = PROD_W - RECIP_SH;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL,
    S_REM,
    S_BUDGET,
    S_FGEN,
    S_SIGN,
    S_INT,
    S_DOT,
    S_FZERO,
    S_FOUT
  } state_t;

  typedef enum logic [2:0] {
    EM_SIGN,
    EM_INT,
    EM_DOT,
    EM_FZERO,
    EM_FDIG,
    EM_ERR
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      mul;
    logic      rem;
    logic      budget_ld;
    logic      fstep;
    logic      emit;
    emit_sel_t emit_sel;
  } f2dt_cmd_t;

  typedef struct packed {
    logic too_large;
    logic too_small;
    logic q_zero;
    logic fgen_done;
    logic neg;
    logic int_last;
    logic frac_zero;
    logic budget_zero;
    logic frac_last;
    logic out_free;
  } f2dt_stat_t;

endpackage

// ----- sv/f2dt_if.sv -----
interface f2dt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

interface f2dt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output character, output last, output status, input ready);
  modport sink (input valid, input character, input last, input status, output ready);
endinterface

// ----- sv/f2dt_ctrl.sv -----
module f2dt_ctrl
  import f2dt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  f2dt_stat_t stat,
  output f2dt_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.emit_sel = EM_SIGN;
    in_ready     = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.too_large || stat.too_small) begin
            state_next = S_ERR;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_ERR;
          state_next   = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        // One decimal digit per pass; a zero integer part still yields one digit.
        cmd.rem = 1'b1;
        if (stat.q_zero) begin
          state_next = S_BUDGET;
        end else begin
          state_next = S_MUL;
        end
      end
      S_BUDGET: begin
        cmd.budget_ld = 1'b1;
        state_next    = S_FGEN;
      end
      S_FGEN: begin
        if (stat.fgen_done) begin
          state_next = stat.neg ? S_SIGN : S_INT;
        end else begin
          cmd.fstep = 1'b1;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SIGN;
          state_next   = S_INT;
        end
      end
      S_INT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_INT;
          if (stat.int_last) begin
            state_next = S_DOT;
          end
        end
      end
      S_DOT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_DOT;
          if (stat.frac_zero) begin
            state_next = S_FZERO;
          end else if (stat.budget_zero) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_FOUT;
          end
        end
      end
      S_FZERO: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_FZERO;
          state_next   = S_IDLE;
        end
      end
      S_FOUT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_FDIG;
          if (stat.frac_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/f2dt_datapath.sv -----
module f2dt_datapath
  import f2dt_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] float_bits,
  input  f2dt_cmd_t   cmd,
  output f2dt_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last,
  output logic [1:0]  status
);

  localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int FIX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;

  // Input decode.
  logic [7:0]         bexp;
  logic [23:0]        mant;
  logic               is_zero;
  logic               dec_large;
  logic               dec_small;
  logic [7:0]         sh_l;
  logic [7:0]         sh_r;
  logic [7:0]         sh_f;
  logic [7:0]         sh_n;
  logic [IPART_W-1:0] ipart_d;
  logic [23:0]        frac_d;

  // Working registers.
  logic [IPART_W-1:0] x;
  logic [PROD_W-1:0]  prod;
  logic [3:0]         idig [IDIG_N];
  logic [NDIG_W-1:0]  ndig;
  logic [23:0]        frac;
  logic               frac_zero;
  logic               neg;
  logic [1:0]         err_code;
  logic [3:0]         fdig [MAX_FRAC_DIGITS];
  logic [CNT_W-1:0]   fidx;
  logic [CNT_W-1:0]   fkeep;
  logic [CNT_W-1:0]   budget;

  logic [QUOT_W-1:0]  quot;
  logic [IPART_W:0]   quot10;
  logic [3:0]         rem_digit;
  logic [27:0]        f10;
  logic [NDIG_W-1:0]  ndig_m1;
  logic [CNT_W-1:0]   fcount;
  logic [4:0]         pre;
  logic signed [6:0]  avail_a;
  logic signed [6:0]  avail_b;
  logic signed [6:0]  cap;
  logic [CNT_W-1:0]   budget_d;
  logic               out_free;

  assign bexp      = float_bits[30:23];
  assign mant      = {1'b1, float_bits[22:0]};
  assign is_zero   = (float_bits[30:0] == 31'd0);
  assign dec_large = !is_zero && (bexp >= BEXP_LARGE);
  assign dec_small = !is_zero && (bexp < BEXP_SMALL);
  assign sh_l      = bexp - BEXP_INT;
  assign sh_r      = BEXP_INT - bexp;
  assign sh_f      = bexp - BEXP_HALF;
  assign sh_n      = BEXP_HALF - bexp;

  always_comb begin
    ipart_d = '0;
    frac_d  = '0;
    if (is_zero) begin
      ipart_d = '0;
    end else if (bexp >= BEXP_INT) begin
      ipart_d = {7'd0, mant} << sh_l[2:0];
    end else if (bexp >= BEXP_ONE) begin
      ipart_d = IPART_W'(mant >> sh_r[4:0]);
      frac_d  = mant << sh_f[4:0];
    end else begin
      frac_d = mant >> sh_n[4:0];
    end
  end

  // Remainder after the reciprocal multiply: x - 10*q.
  assign quot      = prod[PROD_W-1:RECIP_SH];
  assign quot10    = (IPART_W+1)'({quot, 3'b000}) + (IPART_W+1)'({quot, 1'b0});
  assign rem_digit = 4'({1'b0, x} - quot10);
  assign f10       = 28'({frac, 3'b000}) + 28'({frac, 1'b0});
  assign ndig_m1   = ndig - NDIG_W'(1);

  // Fraction digit budget from the characters ahead of the point.
  assign pre     = 5'(ndig) + 5'(neg) + 5'd1;
  assign avail_a = 7'(TEXT_BUFFER_LEN - 1) - $signed({2'b00, pre});
  assign avail_b = 7'(MAX_TEXT) - $signed({2'b00, pre});
  assign cap     = (avail_a < avail_b) ? avail_a : avail_b;

  always_comb begin
    if (cap <= 7'sd0) begin
      budget_d = '0;
    end else if (cap > 7'(MAX_FRAC_DIGITS)) begin
      budget_d = CNT_W'(MAX_FRAC_DIGITS);
    end else begin
      budget_d = cap[CNT_W-1:0];
    end
  end

  // At least one digit stays when every generated digit is zero.
  assign fcount   = (fkeep == '0) ? CNT_W'(1) : fkeep;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x         <= ipart_d;
      frac      <= frac_d;
      frac_zero <= (frac_d == 24'd0);
      neg       <= float_bits[31] && !is_zero;
      err_code  <= dec_large ? ST_TOO_LARGE : ST_TOO_SMALL;
      ndig      <= '0;
      fidx      <= '0;
      fkeep     <= '0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(x) * PROD_W'(RECIP10);
    end
    if (cmd.rem) begin
      idig[ndig[IDX_IW-1:0]] <= rem_digit;
      ndig                   <= ndig + NDIG_W'(1);
      x                      <= IPART_W'(quot);
    end
    if (cmd.budget_ld) begin
      budget <= budget_d;
    end
    if (cmd.fstep) begin
      fdig[fidx[FIX_W-1:0]] <= f10[27:24];
      frac                  <= f10[23:0];
      fidx                  <= fidx + CNT_W'(1);
      if (f10[27:24] != 4'd0) begin
        fkeep <= fidx + CNT_W'(1);
      end
    end
    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        EM_INT:  ndig <= ndig_m1;
        EM_DOT:  fidx <= '0;
        EM_FDIG: fidx <= fidx + CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        EM_SIGN: begin
          character <= CH_MINUS;
          last      <= 1'b0;
          status    <= ST_OK;
        end
        EM_INT: begin
          character <= CH_ZERO | {4'd0, idig[ndig_m1[IDX_IW-1:0]]};
          last      <= 1'b0;
          status    <= ST_OK;
        end
        EM_DOT: begin
          character <= CH_DOT;
          last      <= !frac_zero && (budget == '0);
          status    <= ST_OK;
        end
        EM_FZERO: begin
          character <= CH_ZERO;
          last      <= 1'b1;
          status    <= ST_OK;
        end
        EM_FDIG: begin
          character <= CH_ZERO | {4'd0, fdig[fidx[FIX_W-1:0]]};
          last      <= (fidx == fcount - CNT_W'(1));
          status    <= ST_OK;
        end
        EM_ERR: begin
          character <= CH_NUL;
          last      <= 1'b1;
          status    <= err_code;
        end
        default: begin
          character <= CH_NUL;
          last      <= 1'b1;
          status    <= err_code;
        end
      endcase
    end
  end

  always_comb begin
    stat.too_large   = dec_large;
    stat.too_small   = dec_small;
    stat.q_zero      = (quot == '0);
    stat.fgen_done   = frac_zero || (fidx == budget);
    stat.neg         = neg;
    stat.int_last    = (ndig == NDIG_W'(1));
    stat.frac_zero   = frac_zero;
    stat.budget_zero = (budget == '0);
    stat.frac_last   = (fidx == fcount - CNT_W'(1));
    stat.out_free    = out_free;
  end

endmodule

// ----- sv/float32_to_decimal_text_top.sv -----
// Channel  Dir  Fields                          Beat
// feed     in   float_bits[31:0]                one single-precision pattern
// text     out  character[7:0] last status[1:0] one text character or one error
//
// An item is accepted, each integer digit takes a multiply and a remainder
// step through the reciprocal-of-ten multiplier, the fraction budget is
// loaded, fraction digits are generated and the characters sent; an error
// item sends one error beat. rst clears the sequencer and the output valid.
// A stall on text holds the sequencer; feed is taken only between items.
module float32_to_decimal_text_top
  import f2dt_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = 7
) (
  input logic         clk,
  input logic         rst,
  f2dt_in_if.sink     feed,
  f2dt_out_if.source  text
);

  f2dt_cmd_t  cmd;
  f2dt_stat_t stat;

  f2dt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  f2dt_datapath #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .float_bits (feed.float_bits),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (text.valid),
    .out_ready  (text.ready),
    .character  (text.character),
    .last       (text.last),
    .status     (text.status)
  );

endmodule

// ----- sv/f2dt_checker.sv -----
module f2dt_checker
  import f2dt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] character,
  input logic       last,
  input logic [1:0] status
);

  // An error beat carries no character and closes the item.
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (character == CH_NUL) && last)
    else $error("error beat without nul character and last");

  // Text beats are printable characters.
  a_text_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (character != CH_NUL))
    else $error("text beat carries nul character");

  // Every item yields at least one beat, so a new item is never taken right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last)
      && $stable(status))
    else $error("stalled output beat changed");

endmodule

bind float32_to_decimal_text_top f2dt_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (feed.valid),
  .in_ready  (feed.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .character (text.character),
  .last      (text.last),
  .status    (text.status)
);
